### sv/plnw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plnw_pkg: shared types and constants of the lattice neighbour walker
// Field widths, register indexes, the lattice geometry bundle and the
// per-site record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package plnw_pkg;

    localparam int NUM_DIM_REGS   = 4;    // extent registers in the map
    localparam int DIMS_W         = 3;
    localparam int EXT_W          = 9;
    localparam int COORD_W        = 8;
    localparam int IDX_W          = 32;
    localparam int SEL_W          = 2;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 9;
    localparam int DEF_MAX_DIMS   = 4;
    localparam int DEF_MAX_EXTENT = 256;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DIMS_IN_USE = 3'd0,
        REG_EXTENT_DIM0 = 3'd1,
        REG_EXTENT_DIM1 = 3'd2,
        REG_EXTENT_DIM2 = 3'd3,
        REG_EXTENT_DIM3 = 3'd4
    } t_cfg_reg;

    // Effective geometry: clamped dimension count and extents, row-major
    // strides and wrap spans ((extent - 1) * stride) per dimension.
    typedef struct packed {
        logic [DIMS_W-1:0]                        dims;
        logic [NUM_DIM_REGS-1:0][EXT_W-1:0]       extent;
        logic [NUM_DIM_REGS-1:0][IDX_W-1:0]       stride;
        logic [NUM_DIM_REGS-1:0][IDX_W-1:0]       span;
    } t_geom;

    // One site: its linear index and, per dimension, whether the plus or
    // minus step wraps around the extent.
    typedef struct packed {
        logic [IDX_W-1:0]        lin;
        logic [NUM_DIM_REGS-1:0] plus_wrap;
        logic [NUM_DIM_REGS-1:0] minus_wrap;
    } t_site;

endpackage
`default_nettype wire

### sv/plnw_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plnw_cfg: configuration registers and geometry
// Holds the register map, clamps the values and derives strides and wrap
// spans through a registered multiply chain; busy while that chain settles.
// ----------------------------------------------------------------------------
module plnw_cfg
    import plnw_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int MAX_EXTENT = DEF_MAX_EXTENT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_geom                      o_geom,
    output logic                       o_busy
);

    // settle time covers the registered stride stages and the span register
    localparam int SETTLE   = NUM_DIM_REGS + 1;
    localparam int SETTLE_W = $clog2(SETTLE + 1);

    logic [DIMS_W-1:0]                  r_dims;
    logic [NUM_DIM_REGS-1:0][EXT_W-1:0] r_extent;
    logic [SETTLE_W-1:0]                r_settle;
    logic [NUM_DIM_REGS-1:0][IDX_W-1:0] r_stride, n_stride;
    logic [NUM_DIM_REGS-1:0][IDX_W-1:0] r_span, n_span;
    logic [DIMS_W-1:0]                  dims_eff;
    logic [NUM_DIM_REGS-1:0][EXT_W-1:0] ext_eff;
    logic [NUM_DIM_REGS-1:0][EXT_W-1:0] ext_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims   <= DIMS_W'(1);
            r_extent <= {NUM_DIM_REGS{EXT_W'(1)}};
            r_settle <= SETTLE_W'(SETTLE);
        end else begin
            if (i_cfg_wr_en) begin
                r_settle <= SETTLE_W'(SETTLE);
                case (i_cfg_addr)
                    REG_DIMS_IN_USE: r_dims      <= i_cfg_wdata[DIMS_W-1:0];
                    REG_EXTENT_DIM0: r_extent[0] <= i_cfg_wdata[EXT_W-1:0];
                    REG_EXTENT_DIM1: r_extent[1] <= i_cfg_wdata[EXT_W-1:0];
                    REG_EXTENT_DIM2: r_extent[2] <= i_cfg_wdata[EXT_W-1:0];
                    REG_EXTENT_DIM3: r_extent[3] <= i_cfg_wdata[EXT_W-1:0];
                    default: ;  // unmapped index: ignored
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
        end
    end

    always_comb begin
        logic [EXT_W+IDX_W-1:0] prod;
        if (r_dims == '0)
            dims_eff = DIMS_W'(1);
        else if (r_dims > DIMS_W'(MAX_DIMS))
            dims_eff = DIMS_W'(MAX_DIMS);
        else
            dims_eff = r_dims;
        for (int d = 0; d < NUM_DIM_REGS; d++) begin
            if (r_extent[d] == '0)
                ext_eff[d] = EXT_W'(1);
            else if (r_extent[d] > EXT_W'(MAX_EXTENT))
                ext_eff[d] = EXT_W'(MAX_EXTENT);
            else
                ext_eff[d] = r_extent[d];
            // dimensions out of use do not scale the strides
            ext_used[d] = (DIMS_W'(d) < dims_eff) ? ext_eff[d] : EXT_W'(1);
        end
        n_stride[NUM_DIM_REGS-1] = IDX_W'(1);
        for (int d = 0; d < NUM_DIM_REGS - 1; d++) begin
            prod        = ext_used[d+1] * r_stride[d+1];
            n_stride[d] = prod[IDX_W-1:0];
        end
        for (int d = 0; d < NUM_DIM_REGS; d++) begin
            prod      = (ext_eff[d] - EXT_W'(1)) * r_stride[d];
            n_span[d] = prod[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_stride <= n_stride;
        r_span   <= n_span;
    end

    assign o_geom.dims   = dims_eff;
    assign o_geom.extent = ext_eff;
    assign o_geom.stride = r_stride;
    assign o_geom.span   = r_span;
    assign o_busy        = (r_settle != '0);

endmodule
`default_nettype wire

### sv/plnw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plnw_front: site walker
// Keeps the current coordinates, cleans them up, advances the walk and
// forms the site record (linear index and wrap flags) in the following cycle.
// ----------------------------------------------------------------------------
module plnw_front
    import plnw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept,
    input  wire logic  i_restart,
    input  wire t_geom i_geom,
    output logic       o_valid,
    output t_site      o_site
);

    logic [NUM_DIM_REGS-1:0][COORD_W-1:0] r_coord;
    logic [NUM_DIM_REGS-1:0][COORD_W-1:0] c_san, c_next;
    logic [NUM_DIM_REGS-1:0]              pwrap, mwrap;
    logic [NUM_DIM_REGS-1:0][IDX_W-1:0]   off;
    logic                                 r_b_valid;
    logic [NUM_DIM_REGS-1:0][IDX_W-1:0]   r_b_off;
    logic [NUM_DIM_REGS-1:0]              r_b_pwrap, r_b_mwrap;
    logic [IDX_W-1:0]                     lin_sum;

    always_comb begin
        logic [COORD_W-1:0]         c_in;
        logic                       carry;
        logic [COORD_W+IDX_W-1:0]   prod;
        for (int d = 0; d < NUM_DIM_REGS; d++) begin
            c_in = i_restart ? '0 : r_coord[d];
            if (DIMS_W'(d) >= i_geom.dims || {1'b0, c_in} >= i_geom.extent[d])
                c_san[d] = '0;
            else
                c_san[d] = c_in;
            pwrap[d] = ({1'b0, c_san[d]} + EXT_W'(1)) >= i_geom.extent[d];
            mwrap[d] = (c_san[d] == '0);
            prod     = c_san[d] * i_geom.stride[d];
            off[d]   = prod[IDX_W-1:0];
        end
        // odometer step, least significant dimension first
        carry = 1'b1;
        for (int d = NUM_DIM_REGS - 1; d >= 0; d--) begin
            c_next[d] = c_san[d];
            if (carry && DIMS_W'(d) < i_geom.dims) begin
                if (pwrap[d]) begin
                    c_next[d] = '0;
                end else begin
                    c_next[d] = c_san[d] + COORD_W'(1);
                    carry     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord   <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_accept;
            if (i_accept)
                r_coord <= c_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b_off   <= off;
            r_b_pwrap <= pwrap;
            r_b_mwrap <= mwrap;
        end
    end

    always_comb begin
        lin_sum = '0;
        for (int d = 0; d < NUM_DIM_REGS; d++)
            lin_sum = lin_sum + r_b_off[d];
    end

    assign o_valid           = r_b_valid;
    assign o_site.lin        = lin_sum;
    assign o_site.plus_wrap  = r_b_pwrap;
    assign o_site.minus_wrap = r_b_mwrap;

endmodule
`default_nettype wire

### sv/plnw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plnw_queue: site queue
// Small register FIFO of site records between the walker and the expander.
// ----------------------------------------------------------------------------
module plnw_queue
    import plnw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_site       i_site,
    input  wire logic        i_pop,
    output t_site            o_site,
    output logic             o_empty,
    output logic [QCNT_W-1:0] o_count
);

    t_site               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (do_pop)
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (i_push && !do_pop)
                r_count <= r_count + QCNT_W'(1);
            else if (!i_push && do_pop)
                r_count <= r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_site;
    end

    assign o_site  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

### sv/plnw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plnw_back: neighbour expander
// Steps through the 2*dims neighbours of the head site into an output
// register, one per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module plnw_back
    import plnw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_site_valid,
    input  wire t_site             i_site,
    input  wire t_geom             i_geom,
    output logic                   o_site_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [IDX_W-1:0]       o_site_index,
    output logic [SEL_W-1:0]       o_dim_sel,
    output logic                   o_downward,
    output logic [IDX_W-1:0]       o_neighbour_index,
    output logic                   o_last_of_site
);

    logic [SEL_W-1:0]  r_dim;
    logic              r_dir;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_site_index, r_nb_index;
    logic [SEL_W-1:0]  r_dim_sel;
    logic              r_downward, r_last;
    logic              load, last;
    logic [DIMS_W-1:0] last_dim;
    logic              sub;
    logic [IDX_W-1:0]  mag, nb;

    assign load     = i_site_valid && (!r_out_valid || i_pop);
    assign last_dim = i_geom.dims - DIMS_W'(1);
    assign last     = r_dir && ({1'b0, r_dim} == last_dim);

    // plus step: +stride, or back across the extent by -span
    // minus step: -stride, or forward across the extent by +span
    always_comb begin
        if (!r_dir) begin
            sub = i_site.plus_wrap[r_dim];
            mag = sub ? i_geom.span[r_dim] : i_geom.stride[r_dim];
        end else begin
            sub = !i_site.minus_wrap[r_dim];
            mag = sub ? i_geom.stride[r_dim] : i_geom.span[r_dim];
        end
        nb = sub ? (i_site.lin - mag) : (i_site.lin + mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim       <= '0;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (last) begin
                    r_dim <= '0;
                    r_dir <= 1'b0;
                end else if (r_dir) begin
                    r_dim <= r_dim + SEL_W'(1);
                    r_dir <= 1'b0;
                end else begin
                    r_dir <= 1'b1;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_site_index <= i_site.lin;
            r_dim_sel    <= r_dim;
            r_downward   <= r_dir;
            r_nb_index   <= nb;
            r_last       <= last;
        end
    end

    assign o_site_pop        = load && last;
    assign o_empty           = !r_out_valid;
    assign o_site_index      = r_site_index;
    assign o_dim_sel         = r_dim_sel;
    assign o_downward        = r_downward;
    assign o_neighbour_index = r_nb_index;
    assign o_last_of_site    = r_last;

endmodule
`default_nettype wire

### sv/periodic_lattice_neighbour_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_lattice_neighbour_walker: nearest neighbours on a periodic lattice
// Walks lattice sites in row-major order and emits each site's neighbours.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: a transaction is taken when push is high and full
//   is low; i_restart sends the walk back to the origin for that site.
//   Each input transaction yields 2*dims result transactions (plus then minus
//   neighbour for each dimension); o_last_of_site marks the final one.
//   Result side is a queue: the oldest result is on the o_ ports while empty
//   is low, and it is taken when pop is high.
//   The first result of a site passes through the front register, the site
//   queue and the back end's output register. Throughput: one result per
//   cycle while pop keeps the single-result output register free. Inputs
//   may arrive back to back; a 4-entry site queue absorbs them.
//   Configuration: plain write port, registers 0 (dims_in_use) and 1..4
//   (extent_dim0..3). Strides are rebuilt by a registered multiply chain;
//   full stays high after any write and after reset until the chain settles.
//   Reset: dims 1, all extents 1, walk at the origin, both queues empty.
//   A stalled receiver holds the output register, then the site queue
//   fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module periodic_lattice_neighbour_walker
    import plnw_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int MAX_EXTENT = DEF_MAX_EXTENT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item input
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  i_restart,
    // results
    output logic                       empty,
    input  wire logic                  pop,
    output logic [IDX_W-1:0]           o_site_index,
    output logic [SEL_W-1:0]           o_dim_sel,
    output logic                       o_downward,
    output logic [IDX_W-1:0]           o_neighbour_index,
    output logic                       o_last_of_site,
    // configuration
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_geom              geom;
    logic               cfg_busy;
    logic               accept;
    logic               front_valid;
    t_site              front_site;
    t_site              head_site;
    logic               q_empty;
    logic [QCNT_W-1:0]  q_count;
    logic               site_pop;

    // Credit check: queue occupancy plus the site still in the front stage
    // must leave a free slot.
    assign full   = cfg_busy
                 || ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(front_valid)
                     >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept = push && !full;

    plnw_cfg #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_EXTENT (MAX_EXTENT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_geom      (geom),
        .o_busy      (cfg_busy)
    );

    // front: walker, one site per accepted transaction
    plnw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_restart (i_restart),
        .i_geom    (geom),
        .o_valid   (front_valid),
        .o_site    (front_site)
    );

    plnw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_site  (front_site),
        .i_pop   (site_pop),
        .o_site  (head_site),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // back: one neighbour per cycle into the output register while it is empty or popped
    plnw_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_site_valid      (!q_empty),
        .i_site            (head_site),
        .i_geom            (geom),
        .o_site_pop        (site_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_site_index      (o_site_index),
        .o_dim_sel         (o_dim_sel),
        .o_downward        (o_downward),
        .o_neighbour_index (o_neighbour_index),
        .o_last_of_site    (o_last_of_site)
    );

endmodule
`default_nettype wire
